### src/hca_pkg.sv
// Shared types and constants for the HSV color adjust pipeline.
// No dependencies; every other file in src/ except hca_checker refers to this package by scoped name.
package hca_pkg;

    // Hue geometry in 1/16 degree
    localparam int HUE_SECTOR = 960;
    localparam int HUE_TURN   = 5760;
    localparam int HUE_Q_BITS = 10;          // hue ramp quotient never exceeds one sector

    // Channel and rounding constants
    localparam int CH_MAX      = 255;
    localparam int VAL_ROUND   = 127;        // half of CH_MAX for value rounding
    localparam int ADJ_ROUND   = 2048;       // half LSB of the Q.12 gain product
    localparam int ADJ_SHIFT   = 12;
    localparam int GAIN_ONE    = 4096;
    localparam int OUT_HALF    = 480;        // half a sector, for output rounding
    localparam int OUT_SHIFT   = 6;          // 960 = 64 * 15
    localparam int RECIP15     = 4370;       // ceil(2^16 / 15)
    localparam int RECIP_SHIFT = 16;

    // Value = x / 255 by reciprocal, exact for x below 2^24
    localparam int VAL_RECIP       = 16843010; // ceil(2^32 / 255)
    localparam int VAL_RECIP_SHIFT = 32;
    localparam int VAL_W           = 17;       // value up to 1.0 with up to 16 fraction bits

    // Divider lanes
    localparam int LANES    = 2;
    localparam int LANE_HUE = 0;
    localparam int LANE_SAT = 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_OFFSET = 3'd0,
        CFG_SAT_GAIN   = 3'd1,
        CFG_SAT_BIAS   = 3'd2,
        CFG_VAL_GAIN   = 3'd3,
        CFG_VAL_BIAS   = 3'd4
    } cfg_idx_t;

    // Channel holding the maximum
    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } max_sel_t;

    // Side band carried alongside the divider: hue sign, sector, value
    typedef struct packed {
        logic             neg;
        max_sel_t         sel;
        logic [VAL_W-1:0] val;
    } hue_side_t;

    typedef struct packed {
        logic signed [13:0] hue_offset;
        logic        [15:0] sat_gain;
        logic signed [13:0] sat_bias;
        logic        [15:0] val_gain;
        logic signed [13:0] val_bias;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        hue_offset: 14'sd0,
        sat_gain:   16'(GAIN_ONE),
        sat_bias:   14'sd0,
        val_gain:   16'(GAIN_ONE),
        val_bias:   14'sd0
    };

endpackage

### src/hca_front.sv
// Input register and HSV prep stage: max/min, hue and sat numerators, value by reciprocal.
// Depends on hca_pkg; feeds hca_div.
module hca_front #(
    parameter int FRAC_BITS = 12,
    parameter int QW        = 13
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [7:0]                            red_in,
    input  logic [7:0]                            green_in,
    input  logic [7:0]                            blue_in,
    output logic                                  prep_valid,
    output logic [hca_pkg::LANES-1:0][QW+7:0]     prep_num,
    output logic [hca_pkg::LANES-1:0][7:0]        prep_den,
    output hca_pkg::hue_side_t                    prep_side
);

    localparam int NW  = QW + 8;
    localparam int XW  = FRAC_BITS + 8;
    localparam int VPW = XW + 25;

    logic       a_valid_reg;
    logic [7:0] r_reg, g_reg, b_reg;

    logic [7:0]         mx, mn, d, mag;
    logic signed [8:0]  num;
    hca_pkg::max_sel_t  sel;
    logic [XW-1:0]      vx;
    logic [VPW-1:0]     vprod;

    logic                                  prep_valid_reg;
    logic [hca_pkg::LANES-1:0][NW-1:0]     num_next, num_reg;
    logic [hca_pkg::LANES-1:0][7:0]        den_next, den_reg;
    hca_pkg::hue_side_t                    side_next, side_reg;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg    <= in_valid;
            prep_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg    <= red_in;
            g_reg    <= green_in;
            b_reg    <= blue_in;
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    // max, min and hue sector choice (red wins ties, then green)
    always_comb
    begin
        mx = r_reg;
        if (g_reg > mx)
            mx = g_reg;
        if (b_reg > mx)
            mx = b_reg;
        mn = r_reg;
        if (g_reg < mn)
            mn = g_reg;
        if (b_reg < mn)
            mn = b_reg;
        d = mx - mn;

        if (mx == r_reg)
        begin
            num = $signed({1'b0, g_reg}) - $signed({1'b0, b_reg});
            sel = hca_pkg::SEL_RED;
        end
        else if (mx == g_reg)
        begin
            num = $signed({1'b0, b_reg}) - $signed({1'b0, r_reg});
            sel = hca_pkg::SEL_GREEN;
        end
        else
        begin
            num = $signed({1'b0, r_reg}) - $signed({1'b0, g_reg});
            sel = hca_pkg::SEL_BLUE;
        end
        mag = num[8] ? 8'(-num) : 8'(num);
    end

    // divider operands; zero divisors only occur with zero numerators
    // value = round(max / 255) by reciprocal multiply
    always_comb
    begin
        num_next[hca_pkg::LANE_HUE] = NW'(mag) * NW'(hca_pkg::HUE_SECTOR) + NW'(d[7:1]);
        num_next[hca_pkg::LANE_SAT] = (NW'(d) << FRAC_BITS) + NW'(mx[7:1]);
        den_next[hca_pkg::LANE_HUE] = (d == 8'd0) ? 8'd1 : d;
        den_next[hca_pkg::LANE_SAT] = (mx == 8'd0) ? 8'd1 : mx;
        vx    = (XW'(mx) << FRAC_BITS) + XW'(hca_pkg::VAL_ROUND);
        vprod = VPW'(vx) * VPW'(hca_pkg::VAL_RECIP);
        side_next.neg = num[8];
        side_next.sel = sel;
        side_next.val = hca_pkg::VAL_W'(vprod >> hca_pkg::VAL_RECIP_SHIFT);
    end

    assign prep_valid = prep_valid_reg;
    assign prep_num   = num_reg;
    assign prep_den   = den_reg;
    assign prep_side  = side_reg;

endmodule

### src/hca_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes in lockstep.
// Depends on hca_pkg for the side-band type; used by hsv_color_adjust.
module hca_div #(
    parameter int QW = 13
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [hca_pkg::LANES-1:0][QW+7:0]     num,
    input  logic [hca_pkg::LANES-1:0][7:0]        den,
    input  hca_pkg::hue_side_t                    side,
    output logic                                  out_valid,
    output logic [hca_pkg::LANES-1:0][QW-1:0]     quot,
    output hca_pkg::hue_side_t                    out_side
);

    localparam int NL = hca_pkg::LANES;

    logic [QW-1:0]                 valid_reg;
    logic [NL-1:0][7:0]            rem_reg  [QW];
    logic [NL-1:0][QW-1:0]         work_reg [QW];
    logic [NL-1:0][7:0]            den_reg  [QW];
    hca_pkg::hue_side_t            side_reg [QW];

    logic [NL-1:0][7:0]            rem_next  [QW];
    logic [NL-1:0][QW-1:0]         work_next [QW];

    // one shift-compare-subtract step: {remainder, work shifted with quotient bit}
    function automatic logic [QW+7:0] div_step(
        input logic [7:0]    rem,
        input logic [QW-1:0] work,
        input logic [7:0]    dv
    );
        logic [8:0] trial;
        logic       ge;
        logic [7:0] rem_o;
        trial = {rem, work[QW-1]};
        ge    = (trial >= {1'b0, dv});
        rem_o = ge ? 8'(trial - {1'b0, dv}) : trial[7:0];
        return {rem_o, work[QW-2:0], ge};
    endfunction

    // next value of every stage
    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            {rem_next[0][l], work_next[0][l]} =
                div_step(num[l][QW+7:QW], num[l][QW-1:0], den[l]);
        end
        for (int j = 1; j < QW; j++)
        begin
            for (int l = 0; l < NL; l++)
            begin
                {rem_next[j][l], work_next[j][l]} =
                    div_step(rem_reg[j-1][l], work_reg[j-1][l], den_reg[j-1][l]);
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[QW-2:0], in_valid};
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next[0];
            work_reg[0] <= work_next[0];
            den_reg[0]  <= den;
            side_reg[0] <= side;
            for (int j = 1; j < QW; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                work_reg[j] <= work_next[j];
                den_reg[j]  <= den_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quot      = work_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

### src/hca_back.sv
// Back half: hue rotate/wrap, sat/value gain and bias, HSV to RGB, rounding.
// Six register stages; depends on hca_pkg, fed by hca_div.
module hca_back #(
    parameter int FRAC_BITS = 12,
    parameter int QW        = 13
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  hca_pkg::cfg_t                         cfg,
    input  logic                                  in_valid,
    input  logic [hca_pkg::LANES-1:0][QW-1:0]     quot,
    input  hca_pkg::hue_side_t                    side,
    output logic                                  out_valid,
    output logic [7:0]                            red,
    output logic [7:0]                            green,
    output logic [7:0]                            blue
);

    localparam int F    = FRAC_BITS;
    localparam int PW   = F + 16;            // fraction times Q4.12 gain
    localparam int SUMW = F + 18;
    localparam int CW   = 2 * F + 1;         // chroma
    localparam int TW   = 2 * F + 10;        // channel terms scaled by one sector
    localparam int YW   = 2 * F + 18;
    localparam int ZW   = 12;
    localparam int QPW  = ZW + 13;

    localparam logic signed [SUMW-1:0] SUM_LIM = SUMW'(1) <<< (F + hca_pkg::ADJ_SHIFT);
    localparam logic [F:0]             ONE     = (F + 1)'(1) << F;
    localparam logic signed [15:0]     TURN16  = 16'(hca_pkg::HUE_TURN);
    localparam logic signed [15:0]     TURN2   = 16'(2 * hca_pkg::HUE_TURN);

    logic [5:0] valid_reg;

    // stage 1 -> 2
    logic [12:0]   h0_next, h0_reg;
    logic [PW-1:0] sprod_next, sprod_reg, vprod_next, vprod_reg;
    // stage 2 -> 3
    logic [12:0]   h_next, h_reg;
    logic [F:0]    s_next, s_reg, v_next, v_reg;
    // stage 3 -> 4
    logic [2:0]    sec_next, sec3_reg;
    logic [9:0]    k_next, k_reg;
    logic [CW-1:0] c_next, c_reg;
    logic [F:0]    v3_reg;
    // stage 4 -> 5
    logic [CW-1:0] m_val;
    logic [TW-1:0] full_next, full_reg, ramp_next, ramp_reg, m960_next, m960_reg;
    logic [2:0]    sec4_reg;
    // stage 5 -> 6
    logic [TW-1:0]  term [3];
    logic [ZW-1:0]  z_next [3];
    logic [ZW-1:0]  z_reg  [3];
    // stage 6
    logic [7:0]     ch_next [3];
    logic [7:0]     ch_reg  [3];

    // gain then bias, saturated to 0..1
    function automatic logic [F:0] adjust(
        input logic [PW-1:0]       prod,
        input logic signed [13:0]  bias
    );
        logic signed [SUMW-1:0] sum;
        logic signed [SUMW-1:0] rnd;
        sum = $signed(SUMW'(prod)) + (SUMW'(bias) <<< F);
        rnd = (sum + SUMW'(hca_pkg::ADJ_ROUND)) >>> hca_pkg::ADJ_SHIFT;
        if (sum <= 0)
            return '0;
        else if (sum >= SUM_LIM)
            return ONE;
        else
            return rnd[F:0];
    endfunction

    // stage 1: hue from sector base and ramp quotient, gain products
    always_comb
    begin
        logic [12:0]        base;
        logic signed [14:0] hraw;
        case (side.sel)
            hca_pkg::SEL_GREEN: base = 13'(2 * hca_pkg::HUE_SECTOR);
            hca_pkg::SEL_BLUE:  base = 13'(4 * hca_pkg::HUE_SECTOR);
            default:            base = 13'd0;
        endcase
        if (side.neg)
            hraw = $signed({2'b00, base})
                 - $signed({5'b0, quot[hca_pkg::LANE_HUE][hca_pkg::HUE_Q_BITS-1:0]});
        else
            hraw = $signed({2'b00, base})
                 + $signed({5'b0, quot[hca_pkg::LANE_HUE][hca_pkg::HUE_Q_BITS-1:0]});
        if (hraw < 0)
            h0_next = 13'(hraw + $signed(15'(hca_pkg::HUE_TURN)));
        else
            h0_next = 13'(hraw);
        sprod_next = PW'(quot[hca_pkg::LANE_SAT][F:0]) * PW'(cfg.sat_gain);
        vprod_next = PW'(side.val[F:0]) * PW'(cfg.val_gain);
    end

    // stage 2: hue rotation with wrap, bias and saturation
    always_comb
    begin
        logic signed [15:0] hsum;
        hsum = $signed({3'b000, h0_reg}) + 16'(cfg.hue_offset);
        if (hsum < -TURN16)
            h_next = 13'(hsum + TURN2);
        else if (hsum < 0)
            h_next = 13'(hsum + TURN16);
        else if (hsum < TURN16)
            h_next = 13'(hsum);
        else if (hsum < TURN2)
            h_next = 13'(hsum - TURN16);
        else
            h_next = 13'(hsum - TURN2);
        s_next = adjust(sprod_reg, cfg.sat_bias);
        v_next = adjust(vprod_reg, cfg.val_bias);
    end

    // stage 3: sector and position, chroma
    always_comb
    begin
        logic [12:0] sbase;
        logic [12:0] f;
        if (h_reg >= 13'(5 * hca_pkg::HUE_SECTOR))
            sec_next = 3'd5;
        else if (h_reg >= 13'(4 * hca_pkg::HUE_SECTOR))
            sec_next = 3'd4;
        else if (h_reg >= 13'(3 * hca_pkg::HUE_SECTOR))
            sec_next = 3'd3;
        else if (h_reg >= 13'(2 * hca_pkg::HUE_SECTOR))
            sec_next = 3'd2;
        else if (h_reg >= 13'(hca_pkg::HUE_SECTOR))
            sec_next = 3'd1;
        else
            sec_next = 3'd0;
        sbase = 13'(sec_next) * 13'(hca_pkg::HUE_SECTOR);
        f     = h_reg - sbase;
        k_next = sec_next[0] ? 10'(13'(hca_pkg::HUE_SECTOR) - f) : 10'(f);
        c_next = CW'(v_reg) * CW'(s_reg);
    end

    // stage 4: ramp, full and offset terms, all scaled by one sector
    always_comb
    begin
        m_val     = (CW'(v3_reg) << F) - c_reg;
        full_next = TW'(c_reg) * TW'(hca_pkg::HUE_SECTOR);
        ramp_next = TW'(c_reg) * TW'(k_reg);
        m960_next = TW'(m_val) * TW'(hca_pkg::HUE_SECTOR);
    end

    // stage 5: channel assembly and scale to 0..255 (first division by 64)
    always_comb
    begin
        logic [TW-1:0] x;
        logic [YW-1:0] y;
        case (sec4_reg)
            3'd0:
            begin
                term[0] = full_reg; term[1] = ramp_reg; term[2] = '0;
            end
            3'd1:
            begin
                term[0] = ramp_reg; term[1] = full_reg; term[2] = '0;
            end
            3'd2:
            begin
                term[0] = '0; term[1] = full_reg; term[2] = ramp_reg;
            end
            3'd3:
            begin
                term[0] = '0; term[1] = ramp_reg; term[2] = full_reg;
            end
            3'd4:
            begin
                term[0] = ramp_reg; term[1] = '0; term[2] = full_reg;
            end
            default:
            begin
                term[0] = full_reg; term[1] = '0; term[2] = ramp_reg;
            end
        endcase
        for (int i = 0; i < 3; i++)
        begin
            x = term[i] + m960_reg;
            y = YW'(x) * YW'(hca_pkg::CH_MAX) + (YW'(hca_pkg::OUT_HALF) << (2 * F));
            z_next[i] = y[2 * F + hca_pkg::OUT_SHIFT +: ZW];
        end
    end

    // stage 6: divide by 15 through reciprocal, clamp
    always_comb
    begin
        logic [QPW-1:0] qp;
        logic [QPW-1:0] q;
        for (int i = 0; i < 3; i++)
        begin
            qp = QPW'(z_reg[i]) * QPW'(hca_pkg::RECIP15);
            q  = qp >> hca_pkg::RECIP_SHIFT;
            ch_next[i] = (q > QPW'(hca_pkg::CH_MAX)) ? 8'(hca_pkg::CH_MAX) : q[7:0];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[4:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h0_reg    <= h0_next;
            sprod_reg <= sprod_next;
            vprod_reg <= vprod_next;
            h_reg     <= h_next;
            s_reg     <= s_next;
            v_reg     <= v_next;
            sec3_reg  <= sec_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
            v3_reg    <= v_reg;
            sec4_reg  <= sec3_reg;
            full_reg  <= full_next;
            ramp_reg  <= ramp_next;
            m960_reg  <= m960_next;
            for (int i = 0; i < 3; i++)
            begin
                z_reg[i]  <= z_next[i];
                ch_reg[i] <= ch_next[i];
            end
        end
    end

    assign out_valid = valid_reg[5];
    assign red       = ch_reg[0];
    assign green     = ch_reg[1];
    assign blue      = ch_reg[2];

endmodule

### src/hsv_color_adjust.sv
// HSV color adjust top level: config registers, pipeline, output register with skid.
// Depends on hca_pkg, hca_front, hca_div and hca_back.
//
// Usage:
//   Input channel: in_valid / in_stall with red_in, green_in, blue_in; a pixel
//   transaction completes on a clock edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with red_out, green_out, blue_out.
//   Config: cfg_we writes cfg_data to register cfg_index (0 hue_offset,
//   1 sat_gain, 2 sat_bias, 3 val_gain, 4 val_bias); other indexes are ignored.
//   Write config only while no pixel is in flight.
//   Throughput: one pixel per cycle while in_stall is low. The divider
//   resolves one quotient bit per stage, FRAC_BITS + 1 stages (at least 10).
//   Reset clears all valid bits and returns config to its defaults (gains 1.0,
//   offsets 0); the block accepts pixels on the first cycle after reset.
//   Receiver stall: the output holds its pixel, one more pixel lands in a skid
//   register, then in_stall rises and the whole pipeline freezes until the
//   output drains; nothing is dropped or repeated.
module hsv_color_adjust #(
    parameter int FRAC_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         red_in,
    input  logic [7:0]                         green_in,
    input  logic [7:0]                         blue_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         red_out,
    output logic [7:0]                         green_out,
    output logic [7:0]                         blue_out,
    input  logic                               cfg_we,
    input  logic [hca_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hca_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int QW = (FRAC_BITS + 1 > hca_pkg::HUE_Q_BITS) ? FRAC_BITS + 1
                                                               : hca_pkg::HUE_Q_BITS;

    hca_pkg::cfg_t cfg_reg;

    logic en;
    logic skid_valid_reg, out_valid_reg;
    logic [7:0] skid_r_reg, skid_g_reg, skid_b_reg;
    logic [7:0] out_r_reg, out_g_reg, out_b_reg;

    logic                                    prep_valid;
    logic [hca_pkg::LANES-1:0][QW+7:0]       prep_num;
    logic [hca_pkg::LANES-1:0][7:0]          prep_den;
    hca_pkg::hue_side_t                      prep_side;
    logic                                    div_valid;
    logic [hca_pkg::LANES-1:0][QW-1:0]       div_quot;
    hca_pkg::hue_side_t                      div_side;
    logic                                    last_valid;
    logic [7:0]                              last_r, last_g, last_b;
    logic                                    out_free;

    // pipeline runs whenever the skid register is empty
    assign en       = ~skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign out_free = ~out_valid_reg | ~out_stall;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= hca_pkg::CFG_RESET;
        else if (cfg_we)
        begin
            case (hca_pkg::cfg_idx_t'(cfg_index))
                hca_pkg::CFG_HUE_OFFSET: cfg_reg.hue_offset <= cfg_data[13:0];
                hca_pkg::CFG_SAT_GAIN:   cfg_reg.sat_gain   <= cfg_data;
                hca_pkg::CFG_SAT_BIAS:   cfg_reg.sat_bias   <= cfg_data[13:0];
                hca_pkg::CFG_VAL_GAIN:   cfg_reg.val_gain   <= cfg_data;
                hca_pkg::CFG_VAL_BIAS:   cfg_reg.val_bias   <= cfg_data[13:0];
                default:                 cfg_reg            <= cfg_reg;
            endcase
        end
    end

    hca_front #(
        .FRAC_BITS (FRAC_BITS),
        .QW        (QW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .prep_valid (prep_valid),
        .prep_num   (prep_num),
        .prep_den   (prep_den),
        .prep_side  (prep_side)
    );

    hca_div #(
        .QW (QW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .num       (prep_num),
        .den       (prep_den),
        .side      (prep_side),
        .out_valid (div_valid),
        .quot      (div_quot),
        .out_side  (div_side)
    );

    hca_back #(
        .FRAC_BITS (FRAC_BITS),
        .QW        (QW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (div_valid),
        .quot      (div_quot),
        .side      (div_side),
        .out_valid (last_valid),
        .red       (last_r),
        .green     (last_g),
        .blue      (last_b)
    );

    // output register and skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg | last_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (en && last_valid)
            skid_valid_reg <= 1'b1;
    end

    // output and skid payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_r_reg <= skid_r_reg;
                out_g_reg <= skid_g_reg;
                out_b_reg <= skid_b_reg;
            end
            else
            begin
                out_r_reg <= last_r;
                out_g_reg <= last_g;
                out_b_reg <= last_b;
            end
        end
        else if (en && last_valid)
        begin
            skid_r_reg <= last_r;
            skid_g_reg <= last_g;
            skid_b_reg <= last_b;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_r_reg;
    assign green_out = out_g_reg;
    assign blue_out  = out_b_reg;

endmodule

### src/hca_checker.sv
// Port-level checks for hsv_color_adjust, bound to the top level.
// Depends only on the top-level ports.
module hca_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] red_out,
    input logic [7:0] green_out,
    input logic [7:0] blue_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_out)
            && $stable(green_out) && $stable(blue_out))
        else $error("output transaction changed while stalled");

    // input is only held off while a result sits at the output
    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall high with no pending output");

    // the skid only fills after a stalled output transaction
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall && !in_stall))
        else $error("in_stall rose without an output stall");

    // reset leaves nothing pending and the input open
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("handshake not cleared in reset");

endmodule

bind hsv_color_adjust hca_checker u_hca_checker (.*);

### dv/hsv_color_adjust_tb.sv
// Testbench for hsv_color_adjust: random and directed RGB pixels under several
// register settings, checked against a behavioral HSV predictor. Depends on hca_pkg.
`timescale 1ns / 1ps

module hsv_color_adjust_tb;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    localparam int FB = 12;
    localparam int LATENCY = 21;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [7:0] red_in, green_in, blue_in;
    logic out_valid;
    logic out_stall;
    logic [7:0] red_out, green_out, blue_out;
    logic cfg_we;
    logic [hca_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hca_pkg::CFG_DATA_W-1:0] cfg_data;

    pixel_t pending_px[$];
    pixel_t expected_px[$];
    hca_pkg::cfg_t model_cfg;
    int errors;
    int in_idle_left;
    int out_idle_left;
    bit idle_off;

    hsv_color_adjust #(.FRAC_BITS(FB)) dut (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // saturating gain and bias, result with FB fraction bits
    function automatic longint scale_clamp(longint x, longint gain, longint bias);
        longint one;
        longint sum;
        longint r;
        one = longint'(1) << FB;
        sum = x * gain + bias * one;
        if (sum <= 0)
            return 0;
        if (sum >= (one << 12))
            return one;
        r = (sum + 2048) >>> 12;
        return (r > one) ? one : r;
    endfunction

    function automatic logic [7:0] to_byte(longint unsigned val, longint unsigned dv);
        longint unsigned q;
        q = (val * 255 + dv / 2) / dv;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic pixel_t adjusted_pixel(pixel_t p, hca_pkg::cfg_t c);
        int r, g, b, mx, mn, d, h, num, base, mag, t, sector, f, k;
        longint s, v;
        longint unsigned cc, m, ramp, full, dv;
        longint unsigned ch[3];
        pixel_t o;
        r = p.r;
        g = p.g;
        b = p.b;
        mx = r;
        mn = r;
        h = 0;
        s = 0;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (d > 0)
        begin
            if (mx == r)
            begin
                num = g - b;
                base = 0;
            end
            else if (mx == g)
            begin
                num = b - r;
                base = 2 * hca_pkg::HUE_SECTOR;
            end
            else
            begin
                num = r - g;
                base = 4 * hca_pkg::HUE_SECTOR;
            end
            mag = (num < 0) ? -num : num;
            t = (hca_pkg::HUE_SECTOR * mag + d / 2) / d;
            h = base + ((num < 0) ? -t : t);
            if (h < 0)
                h += hca_pkg::HUE_TURN;
            s = ((longint'(d) << FB) + mx / 2) / mx;
        end
        v = ((longint'(mx) << FB) + 127) / 255;
        h = (h + int'(c.hue_offset)) % hca_pkg::HUE_TURN;
        if (h < 0)
            h += hca_pkg::HUE_TURN;
        s = scale_clamp(s, longint'(c.sat_gain), longint'(c.sat_bias));
        v = scale_clamp(v, longint'(c.val_gain), longint'(c.val_bias));
        cc = v * s;
        m = (longint'(v) << FB) - cc;
        sector = h / hca_pkg::HUE_SECTOR;
        f = h % hca_pkg::HUE_SECTOR;
        k = (sector % 2 == 1) ? (hca_pkg::HUE_SECTOR - f) : f;
        full = cc * hca_pkg::HUE_SECTOR;
        ramp = cc * k;
        m = m * hca_pkg::HUE_SECTOR;
        case (sector)
            0: ch = '{full, ramp, 0};
            1: ch = '{ramp, full, 0};
            2: ch = '{0, full, ramp};
            3: ch = '{0, ramp, full};
            4: ch = '{ramp, 0, full};
            default: ch = '{full, 0, ramp};
        endcase
        dv = longint'(hca_pkg::HUE_SECTOR) << (2 * FB);
        o.r = to_byte(ch[0] + m, dv);
        o.g = to_byte(ch[1] + m, dv);
        o.b = to_byte(ch[2] + m, dv);
        return o;
    endfunction

    // driver: pops pending pixels, random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            red_in <= '0;
            green_in <= '0;
            blue_in <= '0;
            in_idle_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_px.insert(expected_px.size(),
                    adjusted_pixel({red_in, green_in, blue_in}, model_cfg));
            if (!in_valid || !in_stall)
            begin
                if (in_idle_left > 0)
                begin
                    in_idle_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_px.size() > 0 && !idle_off && $urandom_range(0, 19) == 0)
                begin
                    in_idle_left = $urandom_range(1, 15);
                    in_valid <= 1'b0;
                end
                else if (pending_px.size() > 0)
                begin
                    pixel_t p;
                    p = pending_px.pop_front();
                    in_valid <= 1'b1;
                    red_in <= p.r;
                    green_in <= p.g;
                    blue_in <= p.b;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each output transaction and drives out_stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_idle_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_px.size() == 0)
                begin
                    $error("unexpected pixel %0d %0d %0d", red_out, green_out, blue_out);
                    errors++;
                end
                else
                begin
                    pixel_t e;
                    e = expected_px.pop_front();
                    if (red_out !== e.r)
                    begin
                        $error("red_out expected %0d actual %0d", e.r, red_out);
                        errors++;
                    end
                    if (green_out !== e.g)
                    begin
                        $error("green_out expected %0d actual %0d", e.g, green_out);
                        errors++;
                    end
                    if (blue_out !== e.b)
                    begin
                        $error("blue_out expected %0d actual %0d", e.b, blue_out);
                        errors++;
                    end
                end
            end
            if (out_idle_left > 0)
            begin
                out_idle_left--;
                out_stall <= 1'b1;
            end
            else if (!idle_off && $urandom_range(0, 19) == 0)
            begin
                out_idle_left = $urandom_range(0, 14);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // wait for the pipeline to drain completely
    task automatic drain_pipeline();
        while (pending_px.size() > 0 || in_valid || expected_px.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(hca_pkg::cfg_idx_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            hca_pkg::CFG_HUE_OFFSET: model_cfg.hue_offset = val[13:0];
            hca_pkg::CFG_SAT_GAIN: model_cfg.sat_gain = val;
            hca_pkg::CFG_SAT_BIAS: model_cfg.sat_bias = val[13:0];
            hca_pkg::CFG_VAL_GAIN: model_cfg.val_gain = val;
            default: model_cfg.val_bias = val[13:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(int ho, int sg, int sb, int vg, int vb);
        write_reg(hca_pkg::CFG_HUE_OFFSET, 16'(ho));
        write_reg(hca_pkg::CFG_SAT_GAIN, 16'(sg));
        write_reg(hca_pkg::CFG_SAT_BIAS, 16'(sb));
        write_reg(hca_pkg::CFG_VAL_GAIN, 16'(vg));
        write_reg(hca_pkg::CFG_VAL_BIAS, 16'(vb));
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p = $urandom;
        // bias toward greys, blacks and saturated corners
        case ($urandom_range(0, 9))
            0: p.g = p.r;
            1: begin p.g = p.r; p.b = p.r; end
            2: p = '0;
            3: p.r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: ;
        endcase
        return p;
    endfunction

    task automatic add_px(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pixel_t p;
        p.r = r;
        p.g = g;
        p.b = b;
        pending_px.insert(pending_px.size(), p);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            pending_px.insert(pending_px.size(), rand_pixel());
    endtask

    // stimulus
    initial
    begin
        errors = 0;
        idle_off = 0;
        model_cfg = hca_pkg::CFG_RESET;
        cfg_we = 1'b0;
        cfg_index = hca_pkg::CFG_HUE_OFFSET;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: corners, greys, black, each sector, tie on the maximum
        add_px(8'd0, 8'd0, 8'd0);
        add_px(8'd255, 8'd255, 8'd255);
        add_px(8'd128, 8'd128, 8'd128);
        add_px(8'd255, 8'd0, 8'd0);
        add_px(8'd0, 8'd255, 8'd0);
        add_px(8'd0, 8'd0, 8'd255);
        add_px(8'd255, 8'd255, 8'd0);
        add_px(8'd0, 8'd255, 8'd255);
        add_px(8'd255, 8'd0, 8'd255);
        add_px(8'd255, 8'd0, 8'd1);
        add_px(8'd1, 8'd0, 8'd0);
        add_px(8'd200, 8'd100, 8'd50);
        add_px(8'd50, 8'd200, 8'd100);
        add_px(8'd100, 8'd50, 8'd200);
        add_px(8'd255, 8'd254, 8'd253);
        add_px(8'd170, 8'd85, 8'd170);
        queue_random(150);
        drain_pipeline();

        // hue wraps beyond a turn, gains at extremes
        write_all(5760, 65535, 0, 0, 0);
        queue_random(100);
        drain_pipeline();
        write_all(-5760, 0, 4096, 65535, -4096);
        queue_random(100);
        drain_pipeline();
        write_all(8191, 2048, -4096, 8192, 4096);
        queue_random(100);
        drain_pipeline();
        write_all(-8192, 6000, 1000, 3000, -500);
        queue_random(100);
        drain_pipeline();

        // random settings in range
        for (int ph = 0; ph < 3; ph++)
        begin
            write_all($urandom_range(0, 11520) - 5760, $urandom_range(0, 65535),
                      $urandom_range(0, 8192) - 4096, $urandom_range(0, 65535),
                      $urandom_range(0, 8192) - 4096);
            queue_random(80);
            drain_pipeline();
        end

        // last part at full rate, no idling
        write_all(960, 4096, 0, 4096, 0);
        idle_off = 1;
        queue_random(100);
        drain_pipeline();

        if (errors == 0)
            $display("hsv_color_adjust_tb: PASS");
        else
            $display("hsv_color_adjust_tb: FAIL");
        $finish;
    end

    // timeout
    initial
    begin
        #2000000;
        $display("hsv_color_adjust_tb: FAIL");
        $finish;
    end

endmodule
